// ----- sv/ffha_pkg.sv -----
package ffha_pkg;

    localparam int OFFSET_BITS  = 20;
    localparam int ALIGN_BYTES  = 32;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_BLOCKS   = 64;
    localparam int FW           = OFFSET_BITS;
    localparam int CNTW         = 7;
    localparam int MAX_CAP      =
        (((1 << OFFSET_BITS) - HEADER_BYTES) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam logic [FW-1:0] REGION_RESET = FW'(1048544);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_STATS   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_NOMEM   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]    operation;
        logic [FW-1:0] address;
        logic [FW-1:0] request_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [FW-1:0]   result_address;
        logic [FW-1:0]   copy_len;
        logic [FW-1:0]   alloc_sum;
        logic [FW-1:0]   resv_sum;
        logic [FW-1:0]   peak_allocated;
        logic [CNTW-1:0] live_count;
        logic [FW-1:0]   free_sum;
        logic [CNTW-1:0] free_block_count;
        logic [FW-1:0]   largest_free;
    } t_out_item;

    typedef struct packed {
        logic [FW-1:0] start;
        logic [FW-1:0] cap;
        logic [FW-1:0] req;
        logic          used;
    } t_entry;

    localparam int ST_W = 35;

    typedef enum logic [ST_W-1:0] {
        S_INIT    = ST_W'(1) << 0,
        S_IDLE    = ST_W'(1) << 1,
        S_DEC     = ST_W'(1) << 2,
        S_BAD     = ST_W'(1) << 3,
        S_OOM     = ST_W'(1) << 4,
        S_AS_RD   = ST_W'(1) << 5,
        S_AS_CHK  = ST_W'(1) << 6,
        S_AL_FIN  = ST_W'(1) << 7,
        S_FD_RD   = ST_W'(1) << 8,
        S_FD_CHK  = ST_W'(1) << 9,
        S_FR_WR   = ST_W'(1) << 10,
        S_FR_LRD  = ST_W'(1) << 11,
        S_FR_LCHK = ST_W'(1) << 12,
        S_RE_CHK  = ST_W'(1) << 13,
        S_RE_NRD  = ST_W'(1) << 14,
        S_RE_NCHK = ST_W'(1) << 15,
        S_RE_GROW = ST_W'(1) << 16,
        S_RE_AFT  = ST_W'(1) << 17,
        S_RE_FIN  = ST_W'(1) << 18,
        S_MV_INI  = ST_W'(1) << 19,
        S_MV_DONE = ST_W'(1) << 20,
        S_SP_CHK  = ST_W'(1) << 21,
        S_SP_RD   = ST_W'(1) << 22,
        S_SP_WR   = ST_W'(1) << 23,
        S_SP_NEW  = ST_W'(1) << 24,
        S_MG_RD   = ST_W'(1) << 25,
        S_MG_CHK  = ST_W'(1) << 26,
        S_SH_TST  = ST_W'(1) << 27,
        S_SH_RD   = ST_W'(1) << 28,
        S_SH_WR   = ST_W'(1) << 29,
        S_SH_END  = ST_W'(1) << 30,
        S_ST_INI  = ST_W'(1) << 31,
        S_ST_RD   = ST_W'(1) << 32,
        S_ST_ACC  = ST_W'(1) << 33,
        S_DONE    = ST_W'(1) << 34
    } t_state;

    typedef struct packed {
        logic [1:0] op;
        logic       addr_zero;
        logic       req_zero;
        logic       fit;
        logic       key_hit;
        logic       rd_used;
        logic       k_last;
        logic       has_next;
        logic       i_zero;
        logic       split_ok;
        logic       sp_more;
        logic       in_place;
        logic       grow_fit;
        logic       out_free;
    } t_sts;

    typedef struct packed {
        t_state st;
        logic   mg_go;
    } t_cmd;

endpackage

// ----- sv/first_fit_heap_allocator_core.sv -----
// Each transaction works through the one-read-port block table RAM entry by entry:
//   the first-fit scan, the address lookup, split and merge shifts, and a statistics
//   pass over every block in the table.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset or a region write leaves one free block and clears sum, peak and live counts.
module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  ffha_pkg::t_in_item      i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output ffha_pkg::t_out_item     o_out_data,
    input  logic                    i_cfg_we,
    input  logic [ffha_pkg::FW-1:0] i_cfg_data
);
    import ffha_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    ffha_dp #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_accept    (i_in_valid && o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/ffha_ram.sv -----
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ffha_ctrl.sv -----
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cfg_we,
    input  ffha_pkg::t_sts i_sts,
    output ffha_pkg::t_cmd o_cmd,
    output logic           o_in_ready
);
    import ffha_pkg::*;

    t_state r_state, n_state;
    t_state r_fret, n_fret;
    t_state r_ffail, n_ffail;
    t_state r_ret_sp, n_ret_sp;
    t_state r_ret_mg, n_ret_mg;
    logic   r_move, n_move;
    logic   r_mg_cond, n_mg_cond;
    logic   mg_go;
    t_state free_end;

    assign mg_go    = !(r_mg_cond && i_sts.rd_used);
    assign free_end = r_move ? S_MV_DONE : S_ST_INI;

    always_comb begin
        n_state   = r_state;
        n_fret    = r_fret;
        n_ffail   = r_ffail;
        n_ret_sp  = r_ret_sp;
        n_ret_mg  = r_ret_mg;
        n_move    = r_move;
        n_mg_cond = r_mg_cond;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_move   = 1'b0;
                n_ret_sp = S_AL_FIN;
                n_ffail  = S_BAD;
                case (t_op'(i_sts.op))
                    OP_ALLOC: n_state = i_sts.req_zero ? S_BAD : S_AS_RD;
                    OP_FREE: begin
                        n_fret  = S_FR_WR;
                        n_state = i_sts.addr_zero ? S_ST_INI : S_FD_RD;
                    end
                    OP_REALLOC: begin
                        if (i_sts.addr_zero) begin
                            n_state = i_sts.req_zero ? S_BAD : S_AS_RD;
                        end else begin
                            n_fret  = i_sts.req_zero ? S_FR_WR : S_RE_CHK;
                            n_state = S_FD_RD;
                        end
                    end
                    default: n_state = S_ST_INI;
                endcase
            end
            S_BAD, S_OOM, S_MV_DONE, S_RE_FIN: n_state = S_ST_INI;
            S_AS_RD: n_state = S_AS_CHK;
            S_AS_CHK: begin
                if (i_sts.fit) n_state = S_SP_CHK;
                else if (i_sts.k_last) n_state = S_OOM;
                else n_state = S_AS_RD;
            end
            S_AL_FIN: begin
                if (r_move) begin
                    n_fret  = S_FR_WR;
                    n_ffail = S_MV_DONE;
                    n_state = S_FD_RD;
                end else begin
                    n_state = S_ST_INI;
                end
            end
            S_FD_RD: n_state = S_FD_CHK;
            S_FD_CHK: begin
                if (i_sts.key_hit) n_state = i_sts.rd_used ? r_fret : r_ffail;
                else if (i_sts.k_last) n_state = r_ffail;
                else n_state = S_FD_RD;
            end
            S_FR_WR: begin
                if (i_sts.has_next) begin
                    n_mg_cond = 1'b1;
                    n_ret_mg  = S_FR_LRD;
                    n_state   = S_MG_RD;
                end else begin
                    n_state = S_FR_LRD;
                end
            end
            S_FR_LRD: n_state = i_sts.i_zero ? free_end : S_FR_LCHK;
            S_FR_LCHK: begin
                if (i_sts.rd_used) begin
                    n_state = free_end;
                end else begin
                    n_mg_cond = 1'b1;
                    n_ret_mg  = free_end;
                    n_state   = S_MG_RD;
                end
            end
            S_RE_CHK: begin
                if (i_sts.in_place) begin
                    n_ret_sp = S_RE_FIN;
                    n_state  = S_SP_CHK;
                end else begin
                    n_state = i_sts.has_next ? S_RE_NRD : S_MV_INI;
                end
            end
            S_RE_NRD: n_state = S_RE_NCHK;
            S_RE_NCHK: n_state = i_sts.grow_fit ? S_RE_GROW : S_MV_INI;
            S_RE_GROW: begin
                n_mg_cond = 1'b0;
                n_ret_mg  = S_RE_AFT;
                n_state   = S_MG_RD;
            end
            S_RE_AFT: begin
                n_ret_sp = S_RE_FIN;
                n_state  = S_SP_CHK;
            end
            S_MV_INI: begin
                n_move   = 1'b1;
                n_ret_sp = S_AL_FIN;
                n_state  = S_AS_RD;
            end
            S_SP_CHK: begin
                if (!i_sts.split_ok) n_state = r_ret_sp;
                else n_state = i_sts.has_next ? S_SP_RD : S_SP_NEW;
            end
            S_SP_RD: n_state = S_SP_WR;
            S_SP_WR: n_state = i_sts.sp_more ? S_SP_RD : S_SP_NEW;
            S_SP_NEW: begin
                if (i_sts.has_next) begin
                    n_mg_cond = 1'b1;
                    n_ret_mg  = r_ret_sp;
                    n_state   = S_MG_RD;
                end else begin
                    n_state = r_ret_sp;
                end
            end
            S_MG_RD: n_state = S_MG_CHK;
            S_MG_CHK: n_state = mg_go ? S_SH_TST : r_ret_mg;
            S_SH_TST: n_state = i_sts.k_last ? S_SH_END : S_SH_RD;
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: n_state = S_SH_TST;
            S_SH_END: n_state = r_ret_mg;
            S_ST_INI: n_state = S_ST_RD;
            S_ST_RD: n_state = S_ST_ACC;
            S_ST_ACC: n_state = i_sts.k_last ? S_DONE : S_ST_RD;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
        if (i_cfg_we) n_state = S_INIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_move    <= 1'b0;
            r_mg_cond <= 1'b0;
            r_fret    <= S_ST_INI;
            r_ffail   <= S_BAD;
            r_ret_sp  <= S_AL_FIN;
            r_ret_mg  <= S_ST_INI;
        end else begin
            r_state   <= n_state;
            r_move    <= n_move;
            r_mg_cond <= n_mg_cond;
            r_fret    <= n_fret;
            r_ffail   <= n_ffail;
            r_ret_sp  <= n_ret_sp;
            r_ret_mg  <= n_ret_mg;
        end
    end

    assign o_cmd.st    = r_state;
    assign o_cmd.mg_go = mg_go;
    assign o_in_ready  = (r_state == S_IDLE);

endmodule

// ----- sv/ffha_dp.sv -----
module ffha_dp #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffha_pkg::t_cmd                i_cmd,
    input  logic                          i_accept,
    input  ffha_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [ffha_pkg::FW-1:0]       i_cfg_data,
    input  logic                          i_out_ready,
    output ffha_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    output ffha_pkg::t_out_item           o_out_data
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = $bits(t_entry);
    localparam logic [FW-1:0] HDR   = FW'(HEADER_BYTES);
    localparam logic [FW-1:0] ALIGN = FW'(ALIGN_BYTES);
    localparam logic [FW-1:0] MINSP = FW'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [FW-1:0] MAXC  = FW'(MAX_CAP);

    logic [FW-1:0] r_region, n_region;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [FW-1:0] r_alloc, n_alloc;
    logic [FW-1:0] r_res, n_res;
    logic [FW-1:0] r_peak, n_peak;
    logic [CW-1:0] r_live, n_live;
    logic [1:0]    r_op, n_op;
    logic [FW-1:0] r_addr, n_addr;
    logic [FW-1:0] r_req, n_req;
    logic [FW:0]   r_capr, n_capr;
    logic [FW-1:0] r_key, n_key;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    t_entry        r_a, n_a;
    t_entry        r_l, n_l;
    logic [FW-1:0] r_oldcap, n_oldcap;
    logic [FW-1:0] r_moved, n_moved;
    logic [1:0]    r_status, n_status;
    logic [FW-1:0] r_result, n_result;
    logic [FW-1:0] r_copy, n_copy;
    logic [FW-1:0] r_fb, n_fb;
    logic [CW-1:0] r_fc, n_fc;
    logic [FW-1:0] r_lf, n_lf;
    t_out_item     r_out, n_out;
    logic          r_ovalid, n_ovalid;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_wdata;
    logic [EW-1:0] ram_rdata;
    t_entry        rd;
    logic [FW-1:0] cfg_v;
    logic [FW-1:0] sum_alloc;
    logic          out_free;
    logic [CW:0]   k_x, i_x, cnt_x;

    ffha_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_entry'(ram_rdata);
    assign out_free = !r_ovalid || i_out_ready;
    assign k_x      = (CW+1)'(r_k);
    assign i_x      = (CW+1)'(r_i);
    assign cnt_x    = (CW+1)'(r_cnt);

    always_comb begin
        cfg_v = FW'((i_cfg_data / ALIGN_BYTES) * ALIGN);
        if (cfg_v > MAXC) cfg_v = MAXC;
        if (cfg_v < ALIGN) cfg_v = ALIGN;
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.addr_zero = (r_addr == '0);
        o_sts.req_zero  = (r_req == '0);
        o_sts.fit       = !rd.used && ((FW+1)'(rd.cap) >= r_capr);
        o_sts.key_hit   = ((FW+1)'(rd.start) + (FW+1)'(HDR)) == (FW+1)'(r_key);
        o_sts.rd_used   = rd.used;
        o_sts.k_last    = (k_x + (CW+1)'(1)) >= cnt_x;
        o_sts.has_next  = (i_x + (CW+1)'(1)) < cnt_x;
        o_sts.i_zero    = (r_i == '0);
        o_sts.split_ok  = (r_capr <= (FW+1)'(r_a.cap))
                       && ((r_a.cap - r_capr[FW-1:0]) >= MINSP)
                       && (cnt_x < (CW+1)'(MAX_BLOCKS));
        o_sts.sp_more   = k_x > (i_x + (CW+1)'(2));
        o_sts.in_place  = r_capr <= (FW+1)'(r_a.cap);
        o_sts.grow_fit  = !rd.used && (((FW+2)'(r_a.cap) + (FW+2)'(HDR)
                          + (FW+2)'(rd.cap)) >= (FW+2)'(r_capr));
        o_sts.out_free  = out_free;
    end

    always_comb begin
        n_region = r_region;
        n_cnt    = r_cnt;
        n_alloc  = r_alloc;
        n_res    = r_res;
        n_peak   = r_peak;
        n_live   = r_live;
        n_op     = r_op;
        n_addr   = r_addr;
        n_req    = r_req;
        n_capr   = r_capr;
        n_key    = r_key;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_a      = r_a;
        n_l      = r_l;
        n_oldcap = r_oldcap;
        n_moved  = r_moved;
        n_status = r_status;
        n_result = r_result;
        n_copy   = r_copy;
        n_fb     = r_fb;
        n_fc     = r_fc;
        n_lf     = r_lf;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        sum_alloc = '0;
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = rd;
        ram_raddr = r_k;

        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;

        unique case (i_cmd.st)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{start: '0, cap: r_region, req: '0, used: 1'b0};
                n_cnt   = CW'(1);
                n_alloc = '0;
                n_res   = '0;
                n_peak  = '0;
                n_live  = '0;
            end
            S_IDLE: begin
                if (i_accept) begin
                    n_op   = i_in_data.operation;
                    n_addr = i_in_data.address;
                    n_req  = i_in_data.request_bytes;
                    n_capr = (FW+1)'((((FW+1)'(i_in_data.request_bytes)
                             + (FW+1)'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES);
                end
            end
            S_DEC: begin
                n_status = STS_OK;
                n_result = '0;
                n_copy   = '0;
                n_k      = '0;
                n_key    = r_addr;
            end
            S_BAD: begin
                n_status = STS_INVALID;
                n_result = '0;
            end
            S_OOM: begin
                n_status = STS_NOMEM;
                n_result = '0;
                n_copy   = '0;
            end
            S_AS_CHK, S_FD_CHK: begin
                n_i = r_k;
                n_a = rd;
                n_k = r_k + IW'(1);
            end
            S_AL_FIN: begin
                sum_alloc = r_alloc + r_req;
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = '{start: r_a.start, cap: r_a.cap, req: r_req, used: 1'b1};
                n_alloc  = sum_alloc;
                n_res    = r_res + r_a.cap;
                n_live   = r_live + CW'(1);
                n_peak   = (sum_alloc > r_peak) ? sum_alloc : r_peak;
                n_result = r_a.start + HDR;
                n_k      = '0;
            end
            S_FR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = '{start: r_a.start, cap: r_a.cap, req: '0, used: 1'b0};
                n_alloc = r_alloc - r_a.req;
                n_res   = r_res - r_a.cap;
                n_live  = r_live - CW'(1);
                n_a     = '{start: r_a.start, cap: r_a.cap, req: '0, used: 1'b0};
                n_l     = '{start: r_a.start, cap: r_a.cap, req: '0, used: 1'b0};
                n_j     = r_i;
            end
            S_FR_LRD: ram_raddr = r_i - IW'(1);
            S_FR_LCHK: begin
                n_l = rd;
                n_j = r_i - IW'(1);
            end
            S_RE_CHK: n_oldcap = r_a.cap;
            S_RE_NRD: ram_raddr = r_i + IW'(1);
            S_RE_GROW: begin
                n_l = r_a;
                n_j = r_i;
            end
            S_RE_AFT: n_a.cap = r_l.cap;
            S_RE_FIN: begin
                sum_alloc = r_alloc - r_a.req + r_req;
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = '{start: r_a.start, cap: r_a.cap, req: r_req, used: 1'b1};
                n_alloc  = sum_alloc;
                n_res    = r_res - r_oldcap + r_a.cap;
                n_peak   = (sum_alloc > r_peak) ? sum_alloc : r_peak;
                n_result = r_addr;
            end
            S_MV_INI: begin
                n_k     = '0;
                n_moved = (r_a.req < r_req) ? r_a.req : r_req;
                n_key   = r_a.start + HDR;
            end
            S_MV_DONE: n_copy = r_moved;
            S_SP_CHK: n_k = IW'(r_cnt);
            S_SP_RD: ram_raddr = r_k - IW'(1);
            S_SP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = rd;
                n_k       = r_k - IW'(1);
            end
            S_SP_NEW: begin
                n_l = '{start: r_a.start + HDR + r_capr[FW-1:0],
                        cap:   r_a.cap - r_capr[FW-1:0] - HDR,
                        req:   '0,
                        used:  1'b0};
                ram_we    = 1'b1;
                ram_waddr = r_i + IW'(1);
                ram_wdata = n_l;
                n_a.cap   = r_capr[FW-1:0];
                n_cnt     = r_cnt + CW'(1);
                n_j       = r_i + IW'(1);
            end
            S_MG_RD: ram_raddr = r_j + IW'(1);
            S_MG_CHK: begin
                if (i_cmd.mg_go) begin
                    n_l.cap   = r_l.cap + HDR + rd.cap;
                    ram_we    = 1'b1;
                    ram_waddr = r_j;
                    ram_wdata = '{start: r_l.start, cap: r_l.cap + HDR + rd.cap,
                                  req: r_l.req, used: r_l.used};
                    n_k       = r_j + IW'(1);
                end
            end
            S_SH_RD: ram_raddr = r_k + IW'(1);
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = rd;
                n_k       = r_k + IW'(1);
            end
            S_SH_END: n_cnt = r_cnt - CW'(1);
            S_ST_INI: begin
                n_fb = '0;
                n_fc = '0;
                n_lf = '0;
                n_k  = '0;
            end
            S_ST_ACC: begin
                if (!rd.used) begin
                    n_fb = r_fb + rd.cap;
                    n_fc = r_fc + CW'(1);
                    if (rd.cap > r_lf) n_lf = rd.cap;
                end
                n_k = r_k + IW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid                   = 1'b1;
                    n_out.status               = r_status;
                    n_out.result_address       = r_result;
                    n_out.copy_len             = r_copy;
                    n_out.alloc_sum            = r_alloc;
                    n_out.resv_sum             = r_res;
                    n_out.peak_allocated       = r_peak;
                    n_out.live_count           = CNTW'(r_live);
                    n_out.free_sum             = r_fb;
                    n_out.free_block_count     = CNTW'(r_fc);
                    n_out.largest_free         = r_lf;
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) n_region = cfg_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= REGION_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= CW'(1);
            r_alloc  <= '0;
            r_res    <= '0;
            r_peak   <= '0;
            r_live   <= '0;
        end else begin
            r_region <= n_region;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_alloc  <= n_alloc;
            r_res    <= n_res;
            r_peak   <= n_peak;
            r_live   <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_req    <= n_req;
        r_capr   <= n_capr;
        r_key    <= n_key;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_a      <= n_a;
        r_l      <= n_l;
        r_oldcap <= n_oldcap;
        r_moved  <= n_moved;
        r_status <= n_status;
        r_result <= n_result;
        r_copy   <= n_copy;
        r_fb     <= n_fb;
        r_fc     <= n_fc;
        r_lf     <= n_lf;
        r_out    <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ----- bench/first_fit_heap_allocator_core_tb.sv -----
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    localparam int NB = ffha_pkg::MAX_BLOCKS;
    localparam int DRAIN_CYCLES = 12 * NB;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    t_in_item      in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    t_out_item     out_data;
    logic          cfg_we = 1'b0;
    logic [FW-1:0] cfg_data = '0;

    first_fit_heap_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // heap table shadow
    int unsigned tbl_start [NB];
    int unsigned tbl_cap   [NB];
    int unsigned tbl_req   [NB];
    bit          tbl_used  [NB];
    int unsigned n_blocks, sum_req, sum_cap, peak_req, n_live, region_sz;

    t_in_item  pend_q [$];
    t_out_item heap_result_q [$];
    int        errs = 0;
    bit        taken = 1'b0;
    int        idle_in = 0, idle_out = 0;
    bit        hold_req = 1'b0;
    int        hold_left = 0;

    function automatic int unsigned align_up(int unsigned v);
        return ((v + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void heap_init();
        for (int k = 0; k < NB; k++) begin
            tbl_start[k] = 0; tbl_cap[k] = 0; tbl_req[k] = 0; tbl_used[k] = 0;
        end
        tbl_cap[0] = region_sz;
        n_blocks = 1; sum_req = 0; sum_cap = 0; peak_req = 0; n_live = 0;
    endfunction

    function automatic void set_region(int unsigned value);
        int unsigned v;
        v = ((value & 32'hFFFFF) / ALIGN_BYTES) * ALIGN_BYTES;
        if (v > MAX_CAP) v = MAX_CAP;
        if (v < ALIGN_BYTES) v = ALIGN_BYTES;
        region_sz = v;
        heap_init();
    endfunction

    function automatic void merge_next(int unsigned i);
        if (i + 1 >= n_blocks) return;
        tbl_cap[i] += HEADER_BYTES + tbl_cap[i+1];
        for (int unsigned k = i + 1; k + 1 < n_blocks; k++) begin
            tbl_start[k] = tbl_start[k+1]; tbl_cap[k] = tbl_cap[k+1];
            tbl_req[k] = tbl_req[k+1]; tbl_used[k] = tbl_used[k+1];
        end
        n_blocks--;
    endfunction

    function automatic void split_at(int unsigned i, int unsigned cap);
        int unsigned avail;
        if (cap > tbl_cap[i]) return;
        avail = tbl_cap[i] - cap;
        if (avail < HEADER_BYTES + ALIGN_BYTES || n_blocks >= NB) return;
        for (int unsigned k = n_blocks; k > i + 1; k--) begin
            tbl_start[k] = tbl_start[k-1]; tbl_cap[k] = tbl_cap[k-1];
            tbl_req[k] = tbl_req[k-1]; tbl_used[k] = tbl_used[k-1];
        end
        tbl_start[i+1] = tbl_start[i] + HEADER_BYTES + cap;
        tbl_cap[i+1] = avail - HEADER_BYTES;
        tbl_req[i+1] = 0;
        tbl_used[i+1] = 0;
        tbl_cap[i] = cap;
        n_blocks++;
        if (i + 2 < n_blocks && !tbl_used[i+2]) merge_next(i + 1);
    endfunction

    function automatic int find_live(int unsigned addr);
        for (int unsigned i = 0; i < n_blocks; i++)
            if (tbl_start[i] + HEADER_BYTES == addr) return tbl_used[i] ? int'(i) : -1;
        return -1;
    endfunction

    function automatic int unsigned heap_alloc(int unsigned bytes, output t_status st);
        int unsigned cap;
        if (bytes == 0) begin
            st = STS_INVALID;
            return 0;
        end
        cap = align_up(bytes);
        for (int unsigned i = 0; i < n_blocks; i++) begin
            if (!tbl_used[i] && tbl_cap[i] >= cap) begin
                split_at(i, cap);
                tbl_used[i] = 1; tbl_req[i] = bytes;
                sum_req += bytes; sum_cap += tbl_cap[i]; n_live++;
                if (sum_req > peak_req) peak_req = sum_req;
                st = STS_OK;
                return tbl_start[i] + HEADER_BYTES;
            end
        end
        st = STS_NOMEM;
        return 0;
    endfunction

    function automatic void release_at(int unsigned i);
        sum_req -= tbl_req[i]; sum_cap -= tbl_cap[i]; n_live--;
        tbl_used[i] = 0; tbl_req[i] = 0;
        if (i + 1 < n_blocks && !tbl_used[i+1]) merge_next(i);
        if (i > 0 && !tbl_used[i-1]) merge_next(i - 1);
    endfunction

    function automatic t_status heap_free(int unsigned addr);
        int f;
        if (addr == 0) return STS_OK;
        f = find_live(addr);
        if (f < 0) return STS_INVALID;
        release_at(f);
        return STS_OK;
    endfunction

    function automatic int unsigned heap_realloc(int unsigned addr, int unsigned bytes,
                                                 output t_status st, output int unsigned cp);
        int f;
        int unsigned i, cap, old_cap, moved, old_start, na;
        cp = 0;
        if (addr == 0) return heap_alloc(bytes, st);
        if (bytes == 0) begin
            st = heap_free(addr);
            return 0;
        end
        f = find_live(addr);
        if (f < 0) begin
            st = STS_INVALID;
            return 0;
        end
        i = f;
        cap = align_up(bytes);
        old_cap = tbl_cap[i];
        if (cap <= old_cap || (i + 1 < n_blocks && !tbl_used[i+1] &&
            old_cap + HEADER_BYTES + tbl_cap[i+1] >= cap)) begin
            if (cap > old_cap) merge_next(i);
            split_at(i, cap);
            sum_req -= tbl_req[i]; sum_cap -= old_cap;
            tbl_req[i] = bytes;
            sum_req += bytes; sum_cap += tbl_cap[i];
            if (sum_req > peak_req) peak_req = sum_req;
            st = STS_OK;
            return addr;
        end
        moved = tbl_req[i] < bytes ? tbl_req[i] : bytes;
        old_start = tbl_start[i];
        na = heap_alloc(bytes, st);
        if (st != STS_OK) return 0;
        f = find_live(old_start + HEADER_BYTES);
        if (f >= 0) release_at(f);
        cp = moved;
        return na;
    endfunction

    function automatic t_out_item heap_step(t_in_item it);
        t_out_item   r;
        t_status     st;
        int unsigned res, cp, fb, fc, lf;
        st = STS_OK; res = 0; cp = 0; fb = 0; fc = 0; lf = 0;
        case (t_op'(it.operation))
            OP_ALLOC:   res = heap_alloc(it.address * 0 + it.request_bytes, st);
            OP_FREE:    st = heap_free(it.address);
            OP_REALLOC: res = heap_realloc(it.address, it.request_bytes, st, cp);
            default:    ;
        endcase
        for (int unsigned i = 0; i < n_blocks; i++) begin
            if (!tbl_used[i]) begin
                fb += tbl_cap[i]; fc++;
                if (tbl_cap[i] > lf) lf = tbl_cap[i];
            end
        end
        r.status = st;
        r.result_address = res[FW-1:0];
        r.copy_len = cp[FW-1:0];
        r.alloc_sum = sum_req[FW-1:0];
        r.resv_sum = sum_cap[FW-1:0];
        r.peak_allocated = peak_req[FW-1:0];
        r.live_count = n_live[CNTW-1:0];
        r.free_sum = fb[FW-1:0];
        r.free_block_count = fc[CNTW-1:0];
        r.largest_free = lf[FW-1:0];
        return r;
    endfunction

    function automatic string field_diffs(t_out_item e, t_out_item g);
        string s;
        s = "";
        if (e.status !== g.status) s = {s, " status"};
        if (e.result_address !== g.result_address) s = {s, " result_address"};
        if (e.copy_len !== g.copy_len) s = {s, " copy_len"};
        if (e.alloc_sum !== g.alloc_sum) s = {s, " alloc_sum"};
        if (e.resv_sum !== g.resv_sum) s = {s, " resv_sum"};
        if (e.peak_allocated !== g.peak_allocated) s = {s, " peak_allocated"};
        if (e.live_count !== g.live_count) s = {s, " live_count"};
        if (e.free_sum !== g.free_sum) s = {s, " free_sum"};
        if (e.free_block_count !== g.free_block_count) s = {s, " free_block_count"};
        if (e.largest_free !== g.largest_free) s = {s, " largest_free"};
        return s;
    endfunction

    // monitor: check results, predict on input transactions
    always @(posedge i_clk) begin
        t_out_item e;
        string     d;
        if (i_rst_n && out_valid && out_ready) begin
            if (heap_result_q.size() == 0) begin
                errs++;
                if (errs <= 10) $display("unexpected result %p", out_data);
            end else begin
                e = heap_result_q.pop_front();
                d = field_diffs(e, out_data);
                if (d != "") begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch:%s\n  exp %p\n  got %p", d, e, out_data);
                end
            end
        end
        taken = i_rst_n && in_valid && in_ready;
        if (taken) heap_result_q.push_back(heap_step(in_data));
    end

    // driver
    always @(negedge i_clk) begin
        if (!in_valid || taken) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= idle_in) begin
                in_data <= pend_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) hold_left <= 600;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(negedge i_clk)
        out_ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= idle_out);

    function automatic logic [FW-1:0] pick_addr();
        int r, k, n;
        r = $urandom_range(99);
        if (r < 75 && n_live > 0) begin
            n = $urandom_range(n_live - 1);
            for (k = 0; k < n_blocks; k++) begin
                if (tbl_used[k]) begin
                    if (n == 0) return FW'(tbl_start[k] + HEADER_BYTES);
                    n--;
                end
            end
        end
        if (r < 86) begin
            k = $urandom_range(n_blocks - 1);
            return FW'(tbl_start[k] + HEADER_BYTES);
        end
        if (r < 92) return '0;
        return FW'($urandom);
    endfunction

    function automatic logic [FW-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 70) return FW'($urandom_range(300, 1));
        if (r < 88) return FW'($urandom_range(region_sz / 8 + 1, 1));
        if (r < 96) return FW'($urandom_range(region_sz, 1));
        return FW'($urandom);
    endfunction

    function automatic t_in_item mk(t_op op, logic [FW-1:0] a, logic [FW-1:0] b);
        t_in_item it;
        it.operation = op;
        it.address = a;
        it.request_bytes = b;
        return it;
    endfunction

    task automatic wait_idle();
        while (pend_q.size() != 0 || in_valid || heap_result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_region(logic [FW-1:0] v);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        set_region(v);
    endtask

    task automatic run_random(int count, bit with_hold);
        int r;
        t_op op;
        for (int n = 0; n < count; n += 3) begin
            for (int j = 0; j < 3; j++) begin
                r = $urandom_range(99);
                op = r < 42 ? OP_ALLOC : r < 66 ? OP_FREE : r < 91 ? OP_REALLOC : OP_STATS;
                pend_q.push_back(mk(op, pick_addr(), pick_size()));
            end
            if (with_hold && n == 30) begin
                @(negedge i_clk);
                hold_req <= 1'b1;
                @(negedge i_clk);
                hold_req <= 1'b0;
            end
            while (pend_q.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [FW-1:0] regions [5];
        regions = '{FW'(64), FW'(0), FW'(1048575), FW'(2048), FW'(0)};
        regions[4] = FW'($urandom_range(1048575, 256));
        set_region(REGION_RESET);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pend_q.push_back(mk(OP_STATS, '1, '1));
        pend_q.push_back(mk(OP_ALLOC, '0, '0));
        pend_q.push_back(mk(OP_ALLOC, '0, FW'(1)));
        pend_q.push_back(mk(OP_ALLOC, '0, FW'(32)));
        pend_q.push_back(mk(OP_ALLOC, '0, FW'(33)));
        pend_q.push_back(mk(OP_FREE, '0, '0));
        pend_q.push_back(mk(OP_FREE, FW'(12345), '0));
        pend_q.push_back(mk(OP_FREE, FW'(96), '0));
        pend_q.push_back(mk(OP_FREE, FW'(96), '0));
        pend_q.push_back(mk(OP_REALLOC, FW'(32), FW'(40)));
        pend_q.push_back(mk(OP_REALLOC, FW'(160), FW'(5000)));
        pend_q.push_back(mk(OP_REALLOC, FW'(32), FW'(2000)));
        pend_q.push_back(mk(OP_FREE, FW'(32), '0));
        pend_q.push_back(mk(OP_REALLOC, '0, FW'(100)));
        pend_q.push_back(mk(OP_REALLOC, FW'(777), FW'(10)));
        pend_q.push_back(mk(OP_REALLOC, FW'(160), FW'(10)));
        pend_q.push_back(mk(OP_ALLOC, '0, '1));
        pend_q.push_back(mk(OP_REALLOC, FW'(160), '0));
        pend_q.push_back(mk(OP_ALLOC, '0, FW'(1048544)));
        pend_q.push_back(mk(OP_STATS, '0, '0));
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin idle_in = 0;  idle_out = 0;  end
                1: begin idle_in = 49; idle_out = 0;  end
                2: begin idle_in = 0;  idle_out = 49; end
                default: begin idle_in = 30; idle_out = 30; end
            endcase
            if (ph > 0) write_region(regions[ph - 1]);
            run_random(ph == 3 ? 330 : 210, ph == 1);
            wait_idle();
        end

        if (errs == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
